>>> design/awt_pkg.sv
// ----------------------------------------------------------------------------
// awt_pkg - shared types and helpers of the ASCII/UTF-8 word tokeniser
// Byte classes, word phases, the classified item passed from the intake
// queue to the tokeniser core, and the bundle of token bytes it emits.
// ----------------------------------------------------------------------------
`default_nettype none

package awt_pkg;

  // Default queue depths.
  localparam int unsigned IN_DEPTH_DEF  = 4;
  localparam int unsigned OUT_DEPTH_DEF = 8;

  // Most token bytes that one text byte can release.
  localparam int unsigned EMIT_MAX = 4;
  localparam int unsigned EMIT_CW  = $clog2(EMIT_MAX + 1);

  // Byte classification constants.
  localparam logic [7:0] HIGH_BIT_MIN = 8'h80;
  localparam logic [2:0] LEAD2_TAG    = 3'h6;
  localparam logic [3:0] LEAD3_TAG    = 4'hE;
  localparam logic [4:0] LEAD4_TAG    = 5'h1E;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // Lengths of a UTF-8 character in bytes.
  localparam logic [2:0] LEN_ONE   = 3'd1;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

  typedef enum logic [1:0] {
    CLS_WORD,    // ASCII letter or digit
    CLS_OTHER,   // any other ASCII byte
    CLS_LEAD,    // valid UTF-8 lead byte
    CLS_SINGLE   // high byte that is no valid lead byte
  } awt_cls_t;

  typedef enum logic [1:0] {
    PH_NONE,     // no word in progress
    PH_ONE,      // one character held, nothing emitted
    PH_MANY      // two or more characters seen
  } awt_phase_t;

  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] lc;
    awt_cls_t   cls;
    logic [2:0] len;
    logic       last;
  } awt_item_t;

  typedef struct packed {
    logic [EMIT_CW-1:0]            cnt;
    logic [EMIT_MAX-1:0][7:0]      data;
    logic [EMIT_MAX-1:0]           last;
  } awt_emit_t;

  // Classify one byte and give its lowercased form.
  function automatic awt_item_t awt_classify(input logic [7:0] b);
    awt_item_t it;
    logic      is_digit;
    logic      is_upper;
    logic      is_lower;
    is_digit = (b >= 8'h30) && (b <= 8'h39);
    is_upper = (b >= 8'h41) && (b <= 8'h5A);
    is_lower = (b >= 8'h61) && (b <= 8'h7A);
    it.raw  = b;
    it.lc   = is_upper ? (b + CASE_OFFSET) : b;
    it.len  = LEN_ONE;
    it.last = 1'b0;
    it.cls  = CLS_OTHER;
    if (b < HIGH_BIT_MIN) begin
      it.cls = (is_digit || is_upper || is_lower) ? CLS_WORD : CLS_OTHER;
    end else if (b[7:5] == LEAD2_TAG) begin
      it.cls = CLS_LEAD;
      it.len = LEN_TWO;
    end else if (b[7:4] == LEAD3_TAG) begin
      it.cls = CLS_LEAD;
      it.len = LEN_THREE;
    end else if (b[7:3] == LEAD4_TAG) begin
      it.cls = CLS_LEAD;
      it.len = LEN_FOUR;
    end else begin
      it.cls = CLS_SINGLE;
    end
    return it;
  endfunction

endpackage

`default_nettype wire

>>> design/awt_front.sv
// ----------------------------------------------------------------------------
// awt_front - intake queue of the word tokeniser
// Accepts text bytes, classifies them on entry and keeps them in a short
// queue until the tokeniser core takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module awt_front import awt_pkg::*; #(
  parameter int unsigned DEPTH = IN_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire logic [7:0] in_text_byte,
  input  wire logic       in_end_of_text,
  output logic            in_full,
  output logic            head_valid,
  output awt_item_t       head,
  input  wire logic       head_pop
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  awt_item_t       q_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            push_ok;
  logic            pop_ok;
  awt_item_t       item;

  // Classify the incoming byte and tag the end of the text.
  always_comb begin
    item      = awt_classify(in_text_byte);
    item.last = in_end_of_text;
  end

  assign in_full    = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rd_ptr_r];
  assign push_ok    = in_push && !in_full;
  assign pop_ok     = head_pop && head_valid;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= item;
    end
  end

endmodule

`default_nettype wire

>>> design/awt_back.sv
// ----------------------------------------------------------------------------
// awt_back - tokeniser core
// Runs the word and UTF-8 collection state on one classified byte per cycle while
// the output queue has room, and hands up to four token bytes to it. At the end of a text
// inside an unfinished character it re-processes the bytes collected after the lead.
// ----------------------------------------------------------------------------
`default_nettype none

module awt_back import awt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       head_valid,
  input  wire awt_item_t  head,
  output logic            head_pop,
  input  wire logic       room,
  output awt_emit_t       emit
);

  logic [7:0]  held_r, held_nxt;
  awt_phase_t  phase_r, phase_nxt;
  logic [7:0]  buf_r [4];
  logic [7:0]  buf_nxt [4];
  logic [2:0]  need_r, need_nxt;
  logic [1:0]  have_r, have_nxt;
  logic [7:0]  rep_r [2];
  logic [7:0]  rep_nxt [2];
  logic [1:0]  rep_cnt_r, rep_cnt_nxt;

  logic        rep_act;
  awt_item_t   cur;
  logic        cur_last;
  logic        go;
  logic        collecting;
  logic [2:0]  have_inc;
  logic        complete;

  // Pick the byte to work on: a re-processed byte wins over the queue.
  always_comb begin
    rep_act  = (rep_cnt_r != 2'd0);
    cur      = rep_act ? awt_classify(rep_r[0]) : head;
    cur_last = rep_act ? (rep_cnt_r == 2'd1) : head.last;
    go       = room && (rep_act || head_valid);
    head_pop = go && !rep_act;
    collecting = (need_r != 3'd0);
    have_inc   = {1'b0, have_r} + 3'd1;
    complete   = (have_inc >= need_r);
  end

  // Next state.
  always_comb begin
    held_nxt    = held_r;
    phase_nxt   = phase_r;
    need_nxt    = need_r;
    have_nxt    = have_r;
    buf_nxt     = buf_r;
    rep_nxt     = rep_r;
    rep_cnt_nxt = rep_cnt_r;
    if (go) begin
      if (rep_act) begin
        rep_nxt[0]  = rep_r[1];
        rep_cnt_nxt = rep_cnt_r - 2'd1;
      end
      if (collecting) begin
        buf_nxt[have_r] = cur.raw;
        if (complete) begin
          need_nxt = 3'd0;
          have_nxt = 2'd0;
        end else begin
          have_nxt = have_inc[1:0];
        end
      end else begin
        unique case (cur.cls)
          CLS_WORD: begin
            phase_nxt = (phase_r == PH_NONE) ? PH_ONE : PH_MANY;
            held_nxt  = cur.lc;
          end
          CLS_OTHER, CLS_SINGLE: begin
            phase_nxt = PH_NONE;
            held_nxt  = 8'h00;
          end
          CLS_LEAD: begin
            phase_nxt  = PH_NONE;
            held_nxt   = 8'h00;
            buf_nxt[0] = cur.raw;
            need_nxt   = cur.len;
            have_nxt   = 2'd1;
          end
        endcase
      end
      // End of text: collected bytes after an unfinished lead go round again.
      if (cur_last) begin
        if ((need_nxt != 3'd0) && (have_nxt >= 2'd2)) begin
          rep_nxt[0]  = buf_nxt[1];
          rep_nxt[1]  = buf_nxt[2];
          rep_cnt_nxt = have_nxt - 2'd1;
        end
        held_nxt  = 8'h00;
        phase_nxt = PH_NONE;
        need_nxt  = 3'd0;
        have_nxt  = 2'd0;
      end
    end
  end

  // Token bytes released by this byte.
  always_comb begin
    emit = '0;
    if (go) begin
      if (collecting) begin
        if (complete) begin
          emit.cnt = EMIT_CW'(need_r);
          for (int k = 0; k < 4; k++) begin
            emit.data[k] = (2'(k) == have_r) ? cur.raw : buf_r[k];
            emit.last[k] = (3'(k + 1) == need_r);
          end
        end
      end else begin
        unique case (cur.cls)
          CLS_WORD: begin
            if (phase_r != PH_NONE) begin
              emit.data[0] = held_r;
              emit.cnt     = EMIT_CW'(1);
              if (cur_last) begin
                emit.data[1] = cur.lc;
                emit.last[1] = 1'b1;
                emit.cnt     = EMIT_CW'(2);
              end
            end
          end
          CLS_OTHER, CLS_LEAD: begin
            if (phase_r == PH_MANY) begin
              emit.data[0] = held_r;
              emit.last[0] = 1'b1;
              emit.cnt     = EMIT_CW'(1);
            end
          end
          CLS_SINGLE: begin
            if (phase_r == PH_MANY) begin
              emit.data[0] = held_r;
              emit.last[0] = 1'b1;
              emit.data[1] = cur.raw;
              emit.last[1] = 1'b1;
              emit.cnt     = EMIT_CW'(2);
            end else begin
              emit.data[0] = cur.raw;
              emit.last[0] = 1'b1;
              emit.cnt     = EMIT_CW'(1);
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= 8'h00;
      phase_r   <= PH_NONE;
      need_r    <= 3'd0;
      have_r    <= 2'd0;
      rep_cnt_r <= 2'd0;
    end else begin
      held_r    <= held_nxt;
      phase_r   <= phase_nxt;
      need_r    <= need_nxt;
      have_r    <= have_nxt;
      rep_cnt_r <= rep_cnt_nxt;
    end
  end

  // Character buffer and re-process bytes carry no reset.
  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    rep_r <= rep_nxt;
  end

endmodule

`default_nettype wire

>>> design/awt_outq.sv
// ----------------------------------------------------------------------------
// awt_outq - token output queue
// Takes up to four token bytes per cycle from the tokeniser core and presents
// them one at a time, oldest first, to the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module awt_outq import awt_pkg::*; #(
  parameter int unsigned DEPTH = OUT_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire awt_emit_t  emit,
  output logic            room,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      token_byte,
  output logic            token_end
);

  // DEPTH must be at least EMIT_MAX.
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [7:0]    data_r [DEPTH];
  logic          end_r  [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] widx [EMIT_MAX];
  logic [AW:0]   sum;
  logic [AW:0]   adv;
  logic          pop_ok;

  assign empty      = (cnt_r == '0);
  assign room       = (cnt_r <= CW'(DEPTH - EMIT_MAX));
  assign token_byte = data_r[rd_ptr_r];
  assign token_end  = end_r[rd_ptr_r];
  assign pop_ok     = pop && !empty;

  // Write addresses of the incoming bytes, wrapping round the queue.
  always_comb begin
    for (int i = 0; i < EMIT_MAX; i++) begin
      sum = {1'b0, wr_ptr_r} + (AW + 1)'(i);
      if (sum >= (AW + 1)'(DEPTH)) begin
        sum = sum - (AW + 1)'(DEPTH);
      end
      widx[i] = sum[AW-1:0];
    end
    adv = {1'b0, wr_ptr_r} + (AW + 1)'(emit.cnt);
    if (adv >= (AW + 1)'(DEPTH)) begin
      adv = adv - (AW + 1)'(DEPTH);
    end
  end

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = adv[AW-1:0];
    rd_ptr_nxt = rd_ptr_r;
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    cnt_nxt = cnt_r + CW'(emit.cnt) - CW'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    for (int i = 0; i < EMIT_MAX; i++) begin
      if (EMIT_CW'(i) < emit.cnt) begin
        data_r[widx[i]] <= emit.data[i];
        end_r[widx[i]]  <= emit.last[i];
      end
    end
  end

endmodule

`default_nettype wire

>>> design/ascii_utf8_word_tokenizer.sv
// Order: a token byte enters the output queue when the core takes the text byte
//   that releases it; a word's newest character waits for the next byte.
// Throughput: one text byte per cycle, set by the core, while the output queue has room;
//   at a text end inside an unfinished UTF-8 character, re-processed bytes go first.
// Reset: synchronous, active low; clears both queues and the tokeniser state.
// ----------------------------------------------------------------------------
// ascii_utf8_word_tokenizer - top level of the word tokeniser
// Intake queue with byte classification, tokeniser core and token output
// queue, each with its own handshake so either side can stall.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_utf8_word_tokenizer import awt_pkg::*; #(
  parameter int unsigned IN_DEPTH  = IN_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire logic [7:0] in_text_byte,
  input  wire logic       in_end_of_text,
  output logic            in_full,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [7:0]      out_token_byte,
  output logic            out_token_end
);

  logic      head_valid;
  awt_item_t head;
  logic      head_pop;
  logic      room;
  awt_emit_t emit;

  // Intake and classification.
  awt_front #(
    .DEPTH (IN_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .in_full        (in_full),
    .head_valid     (head_valid),
    .head           (head),
    .head_pop       (head_pop)
  );

  // Word and UTF-8 tokeniser core.
  awt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .room       (room),
    .emit       (emit)
  );

  // Token output queue.
  awt_outq #(
    .DEPTH (OUT_DEPTH)
  ) u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit       (emit),
    .room       (room),
    .empty      (out_empty),
    .pop        (out_pop),
    .token_byte (out_token_byte),
    .token_end  (out_token_end)
  );

endmodule

`default_nettype wire

>>> design/awt_checker.sv
// ----------------------------------------------------------------------------
// awt_checker - port level checks of the word tokeniser
// Watches the top level's queue handshakes over time.
// ----------------------------------------------------------------------------
`default_nettype none

module awt_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_push,
  input wire logic       in_full,
  input wire logic       out_empty,
  input wire logic       out_pop,
  input wire logic [7:0] out_token_byte,
  input wire logic       out_token_end
);

  // Reset leaves no token waiting.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("token queue not empty after reset");

  // Reset leaves room for input.
  a_reset_room: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("intake queue full after reset");

  // The intake queue only fills up after a byte has been pushed.
  a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push))
    else $error("intake queue became full without a push");

  // A waiting token byte is never withdrawn or altered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_token_byte) && $stable(out_token_end)))
    else $error("waiting token byte changed before it was taken");

endmodule

bind ascii_utf8_word_tokenizer awt_checker u_awt_checker (.*);

`default_nettype wire
